### rtl/csw_pkg.sv
// Shared constants, codes and types for the counting semaphore wait queue.
package csw_pkg;

  // Wait queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths on the ports
  localparam int PID_IN_W  = 8;
  localparam int CFG_W     = 8;
  localparam int COUNT_W   = 9;
  localparam int STATUS_W  = 2;
  localparam int OUT_W     = 24;

  // Count limits
  localparam logic signed [COUNT_W-1:0] COUNT_MAX   = 9'sd255;
  localparam logic [CFG_W-1:0]          COUNT_RESET = 8'd1;

  // Request kinds
  localparam logic REQ_DOWN = 1'b0;
  localparam logic REQ_UP   = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // an item is accepted this cycle
    logic load_cfg;  // reload the count from the config write
  } csw_cmd_t;

  // One result item
  typedef struct packed {
    logic signed [COUNT_W-1:0]  count_now;
    logic [STATUS_W-1:0]        status;
    logic [PID_IN_W-1:0]        woken_id;
    logic                       woken_valid;
    logic                       blocked;
    logic                       granted;
  } csw_result_t;

endpackage

### rtl/csw_ctrl.sv
// Controller: handshake state machine for the input, output and config channels.
module csw_ctrl import csw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output csw_cmd_t cmd
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_HOLD  = 1'b1;

  logic state;
  logic state_next;

  // Output register empty or draining this cycle lets a new item in
  assign s_tready  = (state == ST_EMPTY) || m_tready;
  assign m_tvalid  = (state == ST_HOLD);
  // Config only with nothing held and no item offered
  assign cfg_ready = (state == ST_EMPTY) && !s_tvalid;

  assign cmd.take     = s_tvalid && s_tready;
  assign cmd.load_cfg = cfg_valid && cfg_ready;

  // Next state
  always_comb begin
    priority if (cmd.take) begin
      state_next = ST_HOLD;
    end else if (m_tready) begin
      state_next = ST_EMPTY;
    end else begin
      state_next = state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/csw_dp.sv
// Datapath: semaphore count, ring buffer of waiting IDs and result register.
module csw_dp import csw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  csw_cmd_t           cmd,
  input  logic               req_type,
  input  logic [PID_IN_W-1:0] process_id,
  input  logic [CFG_W-1:0]   initial_count,
  output csw_result_t        result
);

  logic signed [COUNT_W-1:0] sem_count;
  logic signed [COUNT_W-1:0] sem_count_next;
  logic [PTR_W-1:0]          head_ptr;
  logic [PTR_W-1:0]          tail_ptr;
  logic [OCC_W-1:0]          occupancy;
  logic [PID_BITS-1:0]       wait_store [QUEUE_DEPTH];

  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  csw_result_t res_next;

  assign q_full  = (occupancy == OCC_W'(QUEUE_DEPTH));
  assign q_empty = (occupancy == '0);

  // Request decode
  always_comb begin
    push           = 1'b0;
    pop            = 1'b0;
    sem_count_next = sem_count;
    res_next       = '0;
    unique case (req_type)
      REQ_DOWN: begin
        if (sem_count > 9'sd0) begin
          sem_count_next   = sem_count - 9'sd1;
          res_next.granted = 1'b1;
        end else if (q_full) begin
          res_next.status = STATUS_FULL;
        end else begin
          sem_count_next   = sem_count - 9'sd1;
          push             = 1'b1;
          res_next.blocked = 1'b1;
        end
      end
      REQ_UP: begin
        if (sem_count >= COUNT_MAX) begin
          res_next.status = STATUS_SAT;
        end else begin
          sem_count_next = sem_count + 9'sd1;
          // count still at or below zero after the raise
          if (sem_count[COUNT_W-1] && !q_empty) begin
            pop                  = 1'b1;
            res_next.woken_valid = 1'b1;
            res_next.woken_id    = PID_IN_W'(wait_store[head_ptr]);
          end
        end
      end
      default: ;
    endcase
    res_next.count_now = sem_count_next;
  end

  // Count and queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sem_count <= COUNT_W'(COUNT_RESET);
      head_ptr  <= '0;
      tail_ptr  <= '0;
      occupancy <= '0;
    end else begin
      if (cmd.load_cfg) begin
        sem_count <= COUNT_W'(initial_count);
      end else if (cmd.take) begin
        sem_count <= sem_count_next;
      end
      if (cmd.take && push) begin
        tail_ptr <= (tail_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;
      end
      if (cmd.take && pop) begin
        head_ptr <= (head_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
      end
      if (cmd.take && push) begin
        occupancy <= occupancy + 1'b1;
      end else if (cmd.take && pop) begin
        occupancy <= occupancy - 1'b1;
      end
    end
  end

  // ID store and result register
  always_ff @(posedge clk) begin
    if (cmd.take && push) begin
      wait_store[tail_ptr] <= process_id[PID_BITS-1:0];
    end
    if (cmd.take) begin
      result <= res_next;
    end
  end

endmodule

### rtl/counting_semaphore_wait_queue.sv
// Top level: counting semaphore with a FIFO queue of waiting process IDs.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  s_       | in        | s_tvalid / s_tready  | tuser req_type, tdata process_id
//  m_       | out       | m_tvalid / m_tready  | tdata result fields, see port
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_data initial_count
//
// One item per cycle: the result is computed in the accept cycle and held in the
// output register; the next item enters in the cycle that register drains.
// m_tvalid rises in the cycle after an item is accepted.
// Reset sets the count to 1 and empties the queue; queue entries are not cleared.
// Config writes are taken only while the output register is empty and no input
// item is offered.
module counting_semaphore_wait_queue import csw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                s_tuser,   // [0] req_type
  input  logic [PID_IN_W-1:0] s_tdata,   // [7:0] process_id
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] granted, [1] blocked, [2] woken_valid, [10:3] woken_id,
  // [12:11] status, [21:13] count_now, [23:22] zero
  output logic [OUT_W-1:0]    m_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data
);

  csw_cmd_t    cmd;
  csw_result_t result;

  csw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  csw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (s_tuser),
    .process_id    (s_tdata),
    .initial_count (cfg_data),
    .result        (result)
  );

  assign m_tdata = {2'b00, result};

  // A down is never both granted and queued
  a_grant_block_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("granted and blocked both set");

  // A woken process implies the count is still at or below zero
  a_wake_nonpos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[21] || (m_tdata[21:13] == 9'd0)))
    else $error("wake with positive count");

  // A refused request changes nothing and reports nothing else
  a_refused_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[12:11] != STATUS_OK)) |-> (m_tdata[2:0] == 3'b000))
    else $error("refused request reported grant, block or wake");

  // Input side open while a result is held means it drains this cycle
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    (s_tready && m_tvalid) |-> m_tready)
    else $error("new item accepted over an undelivered result");

endmodule
